// ----- sv/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define SFR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define SFR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/sfr_pkg.sv -----
// shared constants, codes and types of the status frame receiver
package sfr_pkg;

  // frame store size and derived widths
  localparam int MAX_FRAME = 16;
  localparam int IDX_W     = $clog2(MAX_FRAME + 1);

  // frame queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // framing bytes
  localparam logic [7:0] START_A    = 8'hAF;
  localparam logic [7:0] START_B    = 8'hFA;
  localparam logic [7:0] END_B      = 8'hA0;
  localparam logic [7:0] REPLY_ADDR = 8'h40;

  // addresses
  localparam logic [7:0] ADDR_BAT1   = 8'h60;
  localparam logic [7:0] ADDR_BAT2   = 8'h61;
  localparam logic [7:0] ADDR_REMOTE = 8'h30;

  // battery commands
  localparam logic [7:0] CMD_LEVEL = 8'h03;
  localparam logic [7:0] CMD_EXT   = 8'h1F;

  // reply header fields
  localparam logic [7:0] SUB_LEVEL  = 8'h02;
  localparam logic [7:0] SUB_REMOTE = 8'h03;
  localparam logic [7:0] LEN_LONG   = 8'h05;
  localparam logic [7:0] LEN_SHORT  = 8'h04;
  localparam logic [7:0] CK_BASE    = 8'h80;
  localparam logic [7:0] MASK_ALL   = 8'hFF;

  // reply lengths in bytes
  localparam int RLEN_W = 4;
  localparam logic [RLEN_W-1:0] RLEN_NONE  = 4'd0;
  localparam logic [RLEN_W-1:0] RLEN_SHORT = 4'd10;
  localparam logic [RLEN_W-1:0] RLEN_LONG  = 4'd11;

  // led bar: divide by ten via reciprocal, then saturate
  localparam logic [7:0] DIV10_MUL   = 8'd205;
  localparam int         DIV10_SHIFT = 11;
  localparam logic [3:0] LED_MAX     = 4'd10;

  // frame class decided by the front
  typedef enum logic [1:0] {
    OP_STATUS = 2'd0,
    OP_LEVEL  = 2'd1,
    OP_EXT    = 2'd2,
    OP_REMOTE = 2'd3
  } op_t;

  // one finished frame, reduced to what the back needs
  typedef struct packed {
    op_t        op;
    logic       sel_two;
    logic [7:0] b5;
    logic [7:0] b6;
    logic [7:0] b7;
    logic       charge;
  } frame_desc_t;

  // queue handshake between the parts
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

endpackage

// ----- sv/sfr_if.sv -----
// request channels: received bytes in, results out
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] tx_byte;
  logic       last;
  logic [7:0] battery_average;
  logic [3:0] led_count;
  logic       charging;
  logic [7:0] wheel_pins;

  modport source (output valid, output kind, output tx_byte, output last,
                  output battery_average, output led_count, output charging,
                  output wheel_pins, input ready);
  modport sink (input valid, input kind, input tx_byte, input last,
                input battery_average, input led_count, input charging,
                input wheel_pins, output ready);
endinterface

// ----- sv/sfr_front.sv -----
// front part: start hunting, frame collection and classification
module sfr_front (
  input  logic                 clk,
  input  logic                 rst,
  sfr_in_if.sink               in_ch,
  input  sfr_pkg::q_stat_t     q_stat,
  output logic                 push,
  output sfr_pkg::frame_desc_t desc
);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_START   = 3'b010,
    PH_COLLECT = 3'b100
  } phase_t;

  phase_t phase, phase_next;
  logic [sfr_pkg::IDX_W-1:0] byte_index, byte_index_next;
  logic [7:0] fb_addr, fb_addr_next;
  logic [7:0] fb_cmd, fb_cmd_next;
  logic [7:0] fb5, fb5_next;
  logic [7:0] fb6, fb6_next;
  logic [7:0] fb7, fb7_next;
  logic [7:0] fb8, fb8_next;
  logic [7:0] fb9, fb9_next;
  logic       accept;
  logic [7:0] b;

  // a request is taken whenever the queue has room
  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;

  // hunt and collect
  always_comb begin
    phase_next      = phase;
    byte_index_next = byte_index;
    fb_addr_next    = fb_addr;
    fb_cmd_next     = fb_cmd;
    fb5_next        = fb5;
    fb6_next        = fb6;
    fb7_next        = fb7;
    fb8_next        = fb8;
    fb9_next        = fb9;
    push            = 1'b0;
    if (accept) begin
      case (phase)
        PH_COLLECT: begin
          if (byte_index >= sfr_pkg::IDX_W'(sfr_pkg::MAX_FRAME)) begin
            // overlong frame: drop it and this byte
            phase_next      = PH_IDLE;
            byte_index_next = '0;
          end else begin
            if (byte_index == sfr_pkg::IDX_W'(2)) fb_addr_next = b;
            if (byte_index == sfr_pkg::IDX_W'(4)) fb_cmd_next  = b;
            if (byte_index == sfr_pkg::IDX_W'(5)) fb5_next     = b;
            if (byte_index == sfr_pkg::IDX_W'(6)) fb6_next     = b;
            if (byte_index == sfr_pkg::IDX_W'(7)) fb7_next     = b;
            if (byte_index == sfr_pkg::IDX_W'(8)) fb8_next     = b;
            if (byte_index == sfr_pkg::IDX_W'(9)) fb9_next     = b;
            byte_index_next = byte_index + sfr_pkg::IDX_W'(1);
            if (b == sfr_pkg::END_B) begin
              phase_next      = PH_IDLE;
              byte_index_next = '0;
              push            = 1'b1;
            end
          end
        end
        PH_START: begin
          if (b == sfr_pkg::START_B) begin
            // new frame: unreceived bytes read as zero
            fb_addr_next    = '0;
            fb_cmd_next     = '0;
            fb5_next        = '0;
            fb6_next        = '0;
            fb7_next        = '0;
            fb8_next        = '0;
            fb9_next        = '0;
            byte_index_next = sfr_pkg::IDX_W'(2);
            phase_next      = PH_COLLECT;
          end else if (b != sfr_pkg::START_A) begin
            phase_next = PH_IDLE;
          end
        end
        default: begin
          phase_next = (b == sfr_pkg::START_A) ? PH_START : PH_IDLE;
        end
      endcase
    end
  end

  // classify the finished frame, including the end byte itself
  always_comb begin
    desc.op      = sfr_pkg::OP_STATUS;
    desc.sel_two = (fb_addr_next == sfr_pkg::ADDR_BAT2);
    desc.b5      = fb5_next;
    desc.b6      = fb6_next;
    desc.b7      = fb7_next;
    desc.charge  = (fb8_next | fb9_next) != 8'h00;
    if (fb_addr_next == sfr_pkg::ADDR_BAT1 || fb_addr_next == sfr_pkg::ADDR_BAT2) begin
      if (fb_cmd_next == sfr_pkg::CMD_LEVEL) begin
        desc.op = sfr_pkg::OP_LEVEL;
      end else if (fb_cmd_next == sfr_pkg::CMD_EXT) begin
        desc.op = sfr_pkg::OP_EXT;
      end
    end else if (fb_addr_next == sfr_pkg::ADDR_REMOTE) begin
      desc.op = sfr_pkg::OP_REMOTE;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      byte_index <= '0;
    end else begin
      phase      <= phase_next;
      byte_index <= byte_index_next;
    end
  end

  // captured frame bytes
  always_ff @(posedge clk) begin
    fb_addr <= fb_addr_next;
    fb_cmd  <= fb_cmd_next;
    fb5     <= fb5_next;
    fb6     <= fb6_next;
    fb7     <= fb7_next;
    fb8     <= fb8_next;
    fb9     <= fb9_next;
  end

endmodule

// ----- sv/sfr_queue.sv -----
// short queue of finished frames between front and back
module sfr_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  sfr_pkg::frame_desc_t push_desc,
  input  logic                 pop,
  output sfr_pkg::frame_desc_t head_desc,
  output sfr_pkg::q_stat_t     q_stat
);

  sfr_pkg::frame_desc_t slots [sfr_pkg::QDEPTH];
  logic [sfr_pkg::QPTR_W-1:0] wr_ptr;
  logic [sfr_pkg::QPTR_W-1:0] rd_ptr;
  logic [sfr_pkg::QCNT_W-1:0] count;
  logic do_push, do_pop;

  assign q_stat.full      = (count == sfr_pkg::QCNT_W'(sfr_pkg::QDEPTH));
  assign q_stat.not_empty = (count != '0);
  assign do_push          = push && !q_stat.full;
  assign do_pop           = pop && q_stat.not_empty;
  assign head_desc        = slots[rd_ptr];

  // pointers and fill count, wrapping at the depth
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == sfr_pkg::QPTR_W'(sfr_pkg::QDEPTH - 1)) ?
                  '0 : wr_ptr + sfr_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == sfr_pkg::QPTR_W'(sfr_pkg::QDEPTH - 1)) ?
                  '0 : rd_ptr + sfr_pkg::QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + sfr_pkg::QCNT_W'(1);
        2'b01:   count <= count - sfr_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_desc;
  end

endmodule

// ----- sv/sfr_back.sv -----
// back part: applies frame updates and streams status and reply bytes
module sfr_back (
  input  logic                 clk,
  input  logic                 rst,
  input  sfr_pkg::frame_desc_t desc,
  input  sfr_pkg::q_stat_t     q_stat,
  output logic                 pop,
  sfr_out_if.source            out_ch
);

  // lowest set bit of v among bits below nbits
  function automatic logic [7:0] lowest_bit(input logic [7:0] v, input logic [3:0] nbits);
    logic [7:0] r;
    logic       found;
    r     = '0;
    found = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if (!found && v[k] && (k < int'(nbits))) begin
        r[k]  = 1'b1;
        found = 1'b1;
      end
    end
    return r;
  endfunction

  logic       active;
  logic [3:0] ridx;
  logic [sfr_pkg::RLEN_W-1:0] rlen, rlen_next;
  logic [7:0] r3, r3_next, r4, r4_next, r6, r6_next, r7, r7_next, r8, r8_next;
  logic [7:0] level_one, level_one_next, level_two, level_two_next;
  logic [7:0] control_mask, control_mask_next, wheel_mask, wheel_mask_next;
  logic       charge_held, charge_held_next;
  logic [7:0] pins_held, pins_held_next;
  logic [7:0] ext_e, ctl_c, whl_w, ctl_lb, whl_lb;
  logic       fire, is_last;
  logic [8:0] level_sum;
  logic [7:0] avg;
  logic [15:0] led_prod;
  logic [4:0] led_raw;

  assign fire    = out_ch.valid && out_ch.ready;
  assign is_last = ({1'b0, ridx} == {1'b0, rlen});
  assign pop     = q_stat.not_empty && (!active || (fire && is_last));

  // state update for the frame at the head of the queue
  always_comb begin
    level_one_next    = level_one;
    level_two_next    = level_two;
    control_mask_next = control_mask;
    wheel_mask_next   = wheel_mask;
    charge_held_next  = charge_held;
    pins_held_next    = pins_held;
    rlen_next         = sfr_pkg::RLEN_NONE;
    r3_next           = '0;
    r4_next           = '0;
    r6_next           = '0;
    r7_next           = '0;
    r8_next           = '0;
    ext_e             = '0;
    ctl_c             = desc.b6 & control_mask;
    whl_w             = desc.b7 & wheel_mask;
    ctl_lb            = lowest_bit(ctl_c, 4'd5);
    whl_lb            = lowest_bit(whl_w, 4'd8);
    case (desc.op)
      sfr_pkg::OP_LEVEL: begin
        if (desc.sel_two) level_two_next = desc.b7;
        else              level_one_next = desc.b7;
        // an empty level takes the other one
        if (level_one_next == 8'h00) level_one_next = level_two_next;
        if (level_two_next == 8'h00) level_two_next = level_one_next;
        charge_held_next = desc.charge;
        rlen_next = sfr_pkg::RLEN_LONG;
        r3_next   = sfr_pkg::LEN_LONG;
        r4_next   = sfr_pkg::SUB_LEVEL;
        r6_next   = level_one_next;
        r7_next   = level_two_next;
        r8_next   = sfr_pkg::CK_BASE + sfr_pkg::LEN_LONG + sfr_pkg::SUB_LEVEL
                    + level_one_next + level_two_next;
      end
      sfr_pkg::OP_EXT: begin
        if (desc.sel_two) level_two_next = desc.b5;
        else              level_one_next = desc.b5;
        ext_e     = level_one_next | level_two_next;
        rlen_next = sfr_pkg::RLEN_SHORT;
        r3_next   = sfr_pkg::LEN_SHORT;
        r4_next   = sfr_pkg::CMD_EXT;
        r6_next   = ext_e;
        r7_next   = sfr_pkg::CK_BASE + sfr_pkg::LEN_SHORT + sfr_pkg::CMD_EXT + ext_e;
        r8_next   = sfr_pkg::START_A;
      end
      sfr_pkg::OP_REMOTE: begin
        pins_held_next = '0;
        if ((desc.b6 | desc.b7) != 8'h00) begin
          if (ctl_c != 8'h00) begin
            if (ctl_lb != 8'h00) control_mask_next = ctl_lb;
            rlen_next = sfr_pkg::RLEN_LONG;
            r3_next   = sfr_pkg::LEN_LONG;
            r4_next   = sfr_pkg::SUB_REMOTE;
            r6_next   = control_mask_next;
            r7_next   = 8'h00;
            r8_next   = sfr_pkg::CK_BASE + sfr_pkg::LEN_LONG + sfr_pkg::SUB_REMOTE
                        + control_mask_next;
          end else begin
            control_mask_next = sfr_pkg::MASK_ALL;
          end
          if (whl_w != 8'h00) begin
            wheel_mask_next = whl_lb;
            pins_held_next  = whl_lb;
          end else begin
            wheel_mask_next = sfr_pkg::MASK_ALL;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // result sequencer and held state
  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      ridx         <= '0;
      level_one    <= '0;
      level_two    <= '0;
      control_mask <= sfr_pkg::MASK_ALL;
      wheel_mask   <= sfr_pkg::MASK_ALL;
      charge_held  <= 1'b0;
      pins_held    <= '0;
    end else if (pop) begin
      active       <= 1'b1;
      ridx         <= '0;
      level_one    <= level_one_next;
      level_two    <= level_two_next;
      control_mask <= control_mask_next;
      wheel_mask   <= wheel_mask_next;
      charge_held  <= charge_held_next;
      pins_held    <= pins_held_next;
    end else if (fire) begin
      if (is_last) active <= 1'b0;
      else         ridx   <= ridx + 4'd1;
    end
  end

  // reply payload of the frame being streamed
  always_ff @(posedge clk) begin
    if (pop) begin
      rlen <= rlen_next;
      r3   <= r3_next;
      r4   <= r4_next;
      r6   <= r6_next;
      r7   <= r7_next;
      r8   <= r8_next;
    end
  end

  // status fields
  assign level_sum = {1'b0, level_one} + {1'b0, level_two};
  assign avg       = level_sum[8:1];
  assign led_prod  = {8'h00, avg} * {8'h00, sfr_pkg::DIV10_MUL};
  assign led_raw   = led_prod[sfr_pkg::DIV10_SHIFT +: 5];

  // reply byte by position; index zero is the status result
  always_comb begin
    case (ridx)
      4'd1:    out_ch.tx_byte = sfr_pkg::START_A;
      4'd2:    out_ch.tx_byte = sfr_pkg::START_B;
      4'd3:    out_ch.tx_byte = sfr_pkg::REPLY_ADDR;
      4'd4:    out_ch.tx_byte = r3;
      4'd5:    out_ch.tx_byte = r4;
      4'd6:    out_ch.tx_byte = sfr_pkg::REPLY_ADDR;
      4'd7:    out_ch.tx_byte = r6;
      4'd8:    out_ch.tx_byte = r7;
      4'd9:    out_ch.tx_byte = r8;
      4'd10:   out_ch.tx_byte = (rlen == sfr_pkg::RLEN_SHORT) ? sfr_pkg::END_B
                                                              : sfr_pkg::START_A;
      4'd11:   out_ch.tx_byte = sfr_pkg::END_B;
      default: out_ch.tx_byte = 8'h00;
    endcase
  end

  assign out_ch.valid           = active;
  assign out_ch.kind            = (ridx != 4'd0);
  assign out_ch.last            = is_last;
  assign out_ch.battery_average = avg;
  assign out_ch.led_count       = (led_raw > {1'b0, sfr_pkg::LED_MAX}) ?
                                  sfr_pkg::LED_MAX : led_raw[3:0];
  assign out_ch.charging        = charge_held;
  assign out_ch.wheel_pins      = pins_held;

endmodule

// ----- sv/status_frame_receiver_responder_top.sv -----
// top level of the status frame receiver and responder
//
// Takes one received byte per cycle while its four-frame queue has room. The
// front hunts for AF FA, collects the frame up to A0 and queues it with its
// class; the back applies the battery or remote update and then streams one
// result per cycle while the output is ready: the status result and, when
// due, the ten or eleven bytes of the 40 reply frame, stepped by its result
// sequencer and the output handshake. A finished frame is queued and, when the
// back is free, popped into its registers, which drive its first result. Input
// bytes stall only when four finished frames are waiting behind the back.
module status_frame_receiver_responder_top (
  input  logic      clk,
  input  logic      rst,
  sfr_in_if.sink    in_ch,
  sfr_out_if.source out_ch
);

  sfr_pkg::frame_desc_t push_desc;
  sfr_pkg::frame_desc_t head_desc;
  sfr_pkg::q_stat_t     q_stat;
  logic                 push;
  logic                 pop;

  sfr_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .push   (push),
    .desc   (push_desc)
  );

  sfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head_desc (head_desc),
    .q_stat    (q_stat)
  );

  sfr_back u_back (
    .clk    (clk),
    .rst    (rst),
    .desc   (head_desc),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// ----- sv/sfr_checker.sv -----
// port-level checks of the result channel, bound to the top level
`include "assert_macros.svh"

module sfr_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       kind,
  input logic [7:0] tx_byte,
  input logic       last,
  input logic [3:0] led_count
);

  // a stalled result holds
  `SFR_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(tx_byte) && $stable(kind) && $stable(last), "result changed while stalled")

  // status results carry no reply byte
  `SFR_ASSERT_IMP(a_status_zero, out_valid && !kind, tx_byte == 8'h00, "status result with nonzero byte")

  // led bar saturates
  `SFR_ASSERT_IMP(a_led_range, out_valid, led_count <= sfr_pkg::LED_MAX, "led count above ten")

  // a reply always closes with its end byte
  `SFR_ASSERT_IMP(a_reply_end, out_valid && kind && last, tx_byte == sfr_pkg::END_B, "reply not closed by end byte")

endmodule

bind status_frame_receiver_responder_top sfr_checker u_sfr_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .kind      (out_ch.kind),
  .tx_byte   (out_ch.tx_byte),
  .last      (out_ch.last),
  .led_count (out_ch.led_count)
);
